// ----- sv/lbsc_pkg.sv -----
`timescale 1ns / 1ps

package lbsc_pkg;

  // Field formats
  localparam int COORD_WIDTH    = 20;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_WIDTH     = AXIS_FRAC_BITS + 2;
  localparam int COORD_FRAC     = COORD_WIDTH / 2;
  localparam int T_WIDTH        = 32;
  localparam int T_FRAC         = 16;
  localparam int T_SHIFT        = T_FRAC - COORD_FRAC;
  localparam int P_SHIFT        = T_FRAC + AXIS_FRAC_BITS - COORD_FRAC;
  localparam int NUM_FACES      = 6;

  // Internal datapath widths
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PO_W   = DIFF_W + AXIS_WIDTH;
  localparam int PD_W   = 2 * AXIS_WIDTH;
  localparam int BO_W   = PO_W + 2;
  localparam int SD_W   = PD_W + 2;
  localparam int BD_W   = SD_W + 1 - AXIS_FRAC_BITS;
  localparam int NUM_W  = BO_W + 2;
  localparam int DEN_W  = BD_W + 1;
  localparam int NM_W   = NUM_W + T_SHIFT;
  localparam int DIV_W  = DEN_W + T_WIDTH;
  localparam int PROD_W = T_WIDTH + AXIS_WIDTH;
  localparam int RND_W  = PROD_W + 1 - P_SHIFT;
  localparam int SUM_W  = RND_W + 1;

  // Pipeline depth from accepted transaction to result strobe
  localparam int XFORM_STAGES = 4;
  localparam int LATENCY      = XFORM_STAGES + T_WIDTH + 1 + NUM_FACES + 2;

  // Configuration port
  localparam int CFG_W = 3 * COORD_WIDTH;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_BOX_CENTER  = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_EXTENTS = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_AXIS0   = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_AXIS1   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOX_AXIS2   = 3'd4;

  // Hit counts
  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_TOUCH = 2'd1;
  localparam logic [1:0] HIT_CROSS = 2'd2;

  // Interval extremes
  localparam logic [T_WIDTH-1:0] T_MAX = {1'b0, {(T_WIDTH-1){1'b1}}};
  localparam logic [T_WIDTH-1:0] T_MIN = {1'b1, {(T_WIDTH-1){1'b0}}};

  typedef logic [2:0][COORD_WIDTH-1:0] coord3_t;
  typedef logic [2:0][AXIS_WIDTH-1:0]  axis3_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [AXIS_WIDTH-1:0]  dir_x;
    logic signed [AXIS_WIDTH-1:0]  dir_y;
    logic signed [AXIS_WIDTH-1:0]  dir_z;
  } line_in_t;

  typedef struct packed {
    logic [1:0]                    hit_count;
    logic signed [T_WIDTH-1:0]     t_enter;
    logic signed [T_WIDTH-1:0]     t_exit;
    logic signed [COORD_WIDTH-1:0] enter_x;
    logic signed [COORD_WIDTH-1:0] enter_y;
    logic signed [COORD_WIDTH-1:0] enter_z;
    logic signed [COORD_WIDTH-1:0] exit_x;
    logic signed [COORD_WIDTH-1:0] exit_y;
    logic signed [COORD_WIDTH-1:0] exit_z;
  } result_t;

  typedef struct packed {
    logic [NM_W-1:0]    rem;
    logic [DEN_W-1:0]   dvs;
    logic [T_WIDTH-1:0] quo;
    logic               neg;
    logic               ovf;
    logic               par;
    logic               num_pos;
    logic               dpos;
  } face_div_t;

  typedef struct packed {
    logic                           valid;
    line_in_t                       line;
    face_div_t [NUM_FACES-1:0]      face;
  } div_stage_t;

  typedef struct packed {
    logic                              valid;
    line_in_t                          line;
    logic [NUM_FACES-1:0][T_WIDTH-1:0] q;
    logic [NUM_FACES-1:0]              par;
    logic [NUM_FACES-1:0]              num_pos;
    logic [NUM_FACES-1:0]              dpos;
    logic [T_WIDTH-1:0]                t0;
    logic [T_WIDTH-1:0]                t1;
    logic                              alive;
  } clip_stage_t;

  // Clamp a widened sum back to the signed coordinate range
  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic [SUM_W-COORD_WIDTH:0] top;
    logic [COORD_WIDTH-1:0]     res;
    top = v[SUM_W-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- sv/lbsc_xform.sv -----
`timescale 1ns / 1ps

module lbsc_xform (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  lbsc_pkg::line_in_t   line,
  input  lbsc_pkg::coord3_t    center,
  input  lbsc_pkg::coord3_t    extents,
  input  lbsc_pkg::axis3_t [2:0] axis,
  output lbsc_pkg::div_stage_t div_out
);
  import lbsc_pkg::*;

  localparam logic [SD_W:0] SD_HALF = (SD_W+1)'(1) << (AXIS_FRAC_BITS - 1);

  // Stage 1: products of the centered origin and the direction with each axis
  logic                     s1_valid;
  line_in_t                 s1_line;
  logic signed [PO_W-1:0]   s1_po [3][3];
  logic signed [PD_W-1:0]   s1_pd [3][3];
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [AXIS_WIDTH-1:0]  dir [3];

  always_comb begin
    org[0] = line.origin_x;
    org[1] = line.origin_y;
    org[2] = line.origin_z;
    dir[0] = line.dir_x;
    dir[1] = line.dir_y;
    dir[2] = line.dir_z;
    for (int k = 0; k < 3; k++) begin
      diff[k] = DIFF_W'(org[k]) - DIFF_W'($signed(center[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_line <= line;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s1_po[i][k] <= PO_W'(diff[k]) * PO_W'($signed(axis[i][k]));
        s1_pd[i][k] <= PD_W'(dir[k]) * PD_W'($signed(axis[i][k]));
      end
    end
  end

  // Stage 2: sum the products, round the box-frame direction
  logic                    s2_valid;
  line_in_t                s2_line;
  logic signed [BO_W-1:0]  s2_bo [3];
  logic signed [BD_W-1:0]  s2_bd [3];
  logic signed [SD_W-1:0]  sd [3];
  logic signed [SD_W:0]    sdx [3];
  logic signed [SD_W:0]    sdr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd[i]  = SD_W'(s1_pd[i][0]) + SD_W'(s1_pd[i][1]) + SD_W'(s1_pd[i][2]);
      sdx[i] = (SD_W+1)'(sd[i]);
      sdr[i] = sdx[i] + SD_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_line <= s1_line;
    for (int i = 0; i < 3; i++) begin
      s2_bo[i] <= BO_W'(s1_po[i][0]) + BO_W'(s1_po[i][1]) + BO_W'(s1_po[i][2]);
      s2_bd[i] <= BD_W'(sdr[i] >>> AXIS_FRAC_BITS);
    end
  end

  // Stage 3: numerator and denominator of each slab face
  logic                    s3_valid;
  line_in_t                s3_line;
  logic signed [NUM_W-1:0] s3_num [NUM_FACES];
  logic signed [DEN_W-1:0] s3_den [NUM_FACES];
  logic signed [NUM_W-1:0] num_c [NUM_FACES];
  logic signed [DEN_W-1:0] den_c [NUM_FACES];
  logic [NUM_W-1:0]        ext_c [NUM_FACES];
  logic signed [NUM_W-1:0] bo_c [NUM_FACES];

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      ext_c[f] = NUM_W'({extents[f/2], {AXIS_FRAC_BITS{1'b0}}});
      bo_c[f]  = NUM_W'(s2_bo[f/2]);
      if (f % 2 == 1) begin
        num_c[f] = bo_c[f] - ext_c[f];
        den_c[f] = -DEN_W'(s2_bd[f/2]);
      end else begin
        num_c[f] = -bo_c[f] - ext_c[f];
        den_c[f] = DEN_W'(s2_bd[f/2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_line <= s2_line;
    for (int f = 0; f < NUM_FACES; f++) begin
      s3_num[f] <= num_c[f];
      s3_den[f] <= den_c[f];
    end
  end

  // Stage 4: magnitudes, signs and quotient overflow for the divider row
  div_stage_t      s4_next;
  logic [NUM_W-1:0] nabs [NUM_FACES];
  logic [DEN_W-1:0] dabs [NUM_FACES];
  logic [NM_W-1:0]  nmag [NUM_FACES];

  always_comb begin
    s4_next.valid = s3_valid;
    s4_next.line  = s3_line;
    for (int f = 0; f < NUM_FACES; f++) begin
      nabs[f] = s3_num[f][NUM_W-1] ? NUM_W'(-s3_num[f]) : NUM_W'(s3_num[f]);
      dabs[f] = s3_den[f][DEN_W-1] ? DEN_W'(-s3_den[f]) : DEN_W'(s3_den[f]);
      nmag[f] = {nabs[f], {T_SHIFT{1'b0}}};
      s4_next.face[f].rem     = nmag[f];
      s4_next.face[f].dvs     = dabs[f];
      s4_next.face[f].quo     = '0;
      s4_next.face[f].neg     = s3_num[f][NUM_W-1] ^ s3_den[f][DEN_W-1];
      s4_next.face[f].ovf     = DIV_W'(nmag[f]) >= {dabs[f], {T_WIDTH{1'b0}}};
      s4_next.face[f].par     = (s3_den[f] == '0);
      s4_next.face[f].num_pos = !s3_num[f][NUM_W-1] && (s3_num[f] != '0);
      s4_next.face[f].dpos    = !s3_den[f][DEN_W-1] && (s3_den[f] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out <= '0;
    end else begin
      div_out <= s4_next;
    end
  end

endmodule

// ----- sv/lbsc_div_cell.sv -----
`timescale 1ns / 1ps

module lbsc_div_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lbsc_pkg::div_stage_t din,
  output lbsc_pkg::div_stage_t dout
);
  import lbsc_pkg::*;

  div_stage_t       dnext;
  logic [DIV_W-1:0] shifted [NUM_FACES];
  logic [DIV_W:0]   trial [NUM_FACES];

  // Resolve one quotient bit of every face
  always_comb begin
    dnext = din;
    for (int f = 0; f < NUM_FACES; f++) begin
      shifted[f] = DIV_W'(din.face[f].dvs) << BIT;
      trial[f]   = {1'b0, DIV_W'(din.face[f].rem)} - {1'b0, shifted[f]};
      if (!trial[f][DIV_W]) begin
        dnext.face[f].rem      = NM_W'(trial[f]);
        dnext.face[f].quo[BIT] = 1'b1;
      end
    end
  end

  // Advance to the neighbor cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dnext;
    end
  end

endmodule

// ----- sv/lbsc_clip_cell.sv -----
`timescale 1ns / 1ps

module lbsc_clip_cell #(
  parameter int FACE = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lbsc_pkg::clip_stage_t cin,
  output lbsc_pkg::clip_stage_t cout
);
  import lbsc_pkg::*;

  clip_stage_t               cnext;
  logic signed [T_WIDTH-1:0] q;

  // Clip the interval against this face; drop the line once rejected
  always_comb begin
    cnext = cin;
    q     = $signed(cin.q[FACE]);
    if (cin.alive) begin
      if (cin.par[FACE]) begin
        if (cin.num_pos[FACE]) begin
          cnext.alive = 1'b0;
        end
      end else if (cin.dpos[FACE]) begin
        if (q > $signed(cin.t1)) begin
          cnext.alive = 1'b0;
        end else if (q > $signed(cin.t0)) begin
          cnext.t0 = q;
        end
      end else begin
        if (q < $signed(cin.t0)) begin
          cnext.alive = 1'b0;
        end else if (q < $signed(cin.t1)) begin
          cnext.t1 = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cnext;
    end
  end

endmodule

// ----- sv/lbsc_point.sv -----
`timescale 1ns / 1ps

module lbsc_point (
  input  logic                  clk,
  input  logic                  rst,
  input  lbsc_pkg::clip_stage_t cin,
  output logic                  done,
  output lbsc_pkg::result_t     result
);
  import lbsc_pkg::*;

  localparam logic [PROD_W:0] P_HALF = (PROD_W+1)'(1) << (P_SHIFT - 1);

  // Stage A: hit count and the products t * dir
  logic                          a_valid;
  logic                          a_alive;
  logic [1:0]                    a_count;
  logic [T_WIDTH-1:0]            a_t0;
  logic [T_WIDTH-1:0]            a_t1;
  logic signed [COORD_WIDTH-1:0] a_org [3];
  logic signed [PROD_W-1:0]      a_p0 [3];
  logic signed [PROD_W-1:0]      a_p1 [3];
  logic [1:0]                    count_c;
  logic signed [T_WIDTH-1:0]     t1_c;
  logic signed [AXIS_WIDTH-1:0]  dir [3];
  logic signed [COORD_WIDTH-1:0] org [3];

  always_comb begin
    dir[0] = cin.line.dir_x;
    dir[1] = cin.line.dir_y;
    dir[2] = cin.line.dir_z;
    org[0] = cin.line.origin_x;
    org[1] = cin.line.origin_y;
    org[2] = cin.line.origin_z;
    if ($signed(cin.t1) > $signed(cin.t0)) begin
      count_c = HIT_CROSS;
      t1_c    = $signed(cin.t1);
    end else begin
      count_c = HIT_TOUCH;
      t1_c    = $signed(cin.t0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= cin.valid;
    end
    a_alive <= cin.alive;
    a_count <= count_c;
    a_t0    <= cin.t0;
    a_t1    <= t1_c;
    for (int k = 0; k < 3; k++) begin
      a_org[k] <= org[k];
      a_p0[k]  <= PROD_W'($signed(cin.t0)) * PROD_W'(dir[k]);
      a_p1[k]  <= PROD_W'(t1_c) * PROD_W'(dir[k]);
    end
  end

  // Stage B: round, add the origin, saturate; zero everything on a miss
  logic signed [PROD_W:0]  px0 [3];
  logic signed [PROD_W:0]  px1 [3];
  logic signed [PROD_W:0]  pr0 [3];
  logic signed [PROD_W:0]  pr1 [3];
  logic [SUM_W-1:0]        sum0 [3];
  logic [SUM_W-1:0]        sum1 [3];
  logic [COORD_WIDTH-1:0]  pt0 [3];
  logic [COORD_WIDTH-1:0]  pt1 [3];
  result_t                 result_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      px0[k]  = (PROD_W+1)'(a_p0[k]);
      px1[k]  = (PROD_W+1)'(a_p1[k]);
      pr0[k]  = px0[k] + P_HALF;
      pr1[k]  = px1[k] + P_HALF;
      sum0[k] = SUM_W'(a_org[k]) + SUM_W'($signed(RND_W'(pr0[k] >>> P_SHIFT)));
      sum1[k] = SUM_W'(a_org[k]) + SUM_W'($signed(RND_W'(pr1[k] >>> P_SHIFT)));
      pt0[k]  = sat_coord(sum0[k]);
      pt1[k]  = sat_coord(sum1[k]);
    end
    result_next = '0;
    if (a_alive) begin
      result_next.hit_count = a_count;
      result_next.t_enter   = a_t0;
      result_next.t_exit    = a_t1;
      result_next.enter_x   = pt0[0];
      result_next.enter_y   = pt0[1];
      result_next.enter_z   = pt0[2];
      result_next.exit_x    = pt1[0];
      result_next.exit_y    = pt1[1];
      result_next.exit_z    = pt1[2];
    end else begin
      result_next.hit_count = HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    result <= result_next;
  end

endmodule

// ----- sv/line_box_slab_clip_intersection.sv -----
`timescale 1ns / 1ps

// Line versus oriented box intersection by slab clipping.
// Configuration: write cfg_we with cfg_index 0..4 (center, half-extents, axis 0..2)
// and cfg_data, only while no transaction is in flight. Other indexes are ignored.
// Input: a line transaction (origin, direction) is taken at each clock edge with
// start high and busy low; busy stays low, so one line may enter every cycle.
// Output: done is high for one cycle with the matching result; results come out
// in input order and cannot be stalled by the receiver.
// Pipeline, in order from the accepting edge to the edge that takes the result:
// the box-frame transform, a row of 32 divider cells (one quotient bit
// each, six faces in parallel), a saturation register, a row of 6 clip cells
// (one slab face each) and point evaluation.
// Throughput: one line per cycle, fixed by the fully pipelined cell rows.
// Reset (rst, synchronous): clears the box registers to zero and drops every
// transaction in flight; no done appears for lines accepted before reset.
module line_box_slab_clip_intersection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lbsc_pkg::line_in_t            line,
  output logic                          done,
  output lbsc_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [lbsc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lbsc_pkg::CFG_W-1:0]    cfg_data
);
  import lbsc_pkg::*;

  // Box configuration registers
  coord3_t          center;
  coord3_t          extents;
  axis3_t [2:0]     axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      center  <= '0;
      extents <= '0;
      axis    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_CENTER:  center  <= cfg_data;
        REG_BOX_EXTENTS: extents <= cfg_data;
        REG_BOX_AXIS0:   axis[0] <= cfg_data[3*AXIS_WIDTH-1:0];
        REG_BOX_AXIS1:   axis[1] <= cfg_data[3*AXIS_WIDTH-1:0];
        REG_BOX_AXIS2:   axis[2] <= cfg_data[3*AXIS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Transform into the box frame
  div_stage_t div_chain [T_WIDTH+1];

  lbsc_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .in_valid(start && !busy),
    .line    (line),
    .center  (center),
    .extents (extents),
    .axis    (axis),
    .div_out (div_chain[0])
  );

  // Divider row, most significant quotient bit first
  for (genvar g = 0; g < T_WIDTH; g++) begin : g_div
    lbsc_div_cell #(.BIT(T_WIDTH - 1 - g)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (div_chain[g]),
      .dout(div_chain[g+1])
    );
  end

  // Saturate the quotients and open the interval
  div_stage_t  div_tail;
  clip_stage_t fin_next;
  clip_stage_t clip_head;
  clip_stage_t clip_chain [NUM_FACES+1];
  logic        big [NUM_FACES];

  assign div_tail = div_chain[T_WIDTH];

  always_comb begin
    fin_next.valid = div_tail.valid;
    fin_next.line  = div_tail.line;
    fin_next.t0    = T_MIN;
    fin_next.t1    = T_MAX;
    fin_next.alive = 1'b1;
    for (int f = 0; f < NUM_FACES; f++) begin
      big[f] = div_tail.face[f].ovf || div_tail.face[f].quo[T_WIDTH-1];
      if (div_tail.face[f].neg) begin
        fin_next.q[f] = big[f] ? T_MIN : -div_tail.face[f].quo;
      end else begin
        fin_next.q[f] = big[f] ? T_MAX : div_tail.face[f].quo;
      end
      fin_next.par[f]     = div_tail.face[f].par;
      fin_next.num_pos[f] = div_tail.face[f].num_pos;
      fin_next.dpos[f]    = div_tail.face[f].dpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_head <= '0;
    end else begin
      clip_head <= fin_next;
    end
  end

  assign clip_chain[0] = clip_head;

  // Clip row, one slab face per cell in face order
  for (genvar f = 0; f < NUM_FACES; f++) begin : g_clip
    lbsc_clip_cell #(.FACE(f)) u_cell (
      .clk (clk),
      .rst (rst),
      .cin (clip_chain[f]),
      .cout(clip_chain[f+1])
    );
  end

  // Points and result register
  lbsc_point u_point (
    .clk   (clk),
    .rst   (rst),
    .cin   (clip_chain[NUM_FACES]),
    .done  (done),
    .result(result)
  );

  // Every accepted line yields exactly one result after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result strobe missing after pipeline depth");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.hit_count != 2'd3)
    else $error("hit count out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.hit_count == HIT_NONE |->
      result.t_enter == '0 && result.t_exit == '0 && result.enter_x == '0 &&
      result.exit_z == '0)
    else $error("miss carries nonzero fields");

  a_touch_same: assert property (@(posedge clk) disable iff (rst)
    done && result.hit_count == HIT_TOUCH |->
      result.t_enter == result.t_exit && result.enter_x == result.exit_x &&
      result.enter_y == result.exit_y && result.enter_z == result.exit_z)
    else $error("touching result with differing points");

  a_cross_order: assert property (@(posedge clk) disable iff (rst)
    done && result.hit_count == HIT_CROSS |-> result.t_enter < result.t_exit)
    else $error("entry parameter not below exit parameter");

endmodule

// ----- test/line_box_slab_clip_intersection_test.sv -----
`timescale 1ns / 1ps

module line_box_slab_clip_intersection_test;
  import lbsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int LINE_BITS      = $bits(line_in_t);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  line_in_t          line = '0;
  logic              done;
  result_t           result;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_BOX_CENTER;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Box settings held by the predictor
  logic [CFG_W-1:0]  box_regs [5];

  line_in_t          pending_lines [$];
  result_t           expected_hits [$];
  int                send_idle_pct = 0;
  int                mismatches = 0;
  int                lines_sent = 0;
  int                results_seen = 0;
  int                hits_by_count [3];
  int                quiet_cycles = 0;
  bit                timed_out = 1'b0;
  bit                stim_done = 1'b0;

  line_box_slab_clip_intersection i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .line(line), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint round_div_pow2(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Clip one line against the configured box
  function automatic result_t clip_line(line_in_t ln);
    result_t r;
    longint org [3];
    longint dir [3];
    longint diff [3];
    longint bo [3];
    longint bd [3];
    longint t0;
    longint t1;
    longint so;
    longint sd;
    longint a;
    longint ext;
    longint denom;
    longint numer;
    longint q;
    bit alive;
    int ax;
    logic [COORD_WIDTH-1:0] pt [2][3];
    org[0] = longint'(ln.origin_x);
    org[1] = longint'(ln.origin_y);
    org[2] = longint'(ln.origin_z);
    dir[0] = longint'(ln.dir_x);
    dir[1] = longint'(ln.dir_y);
    dir[2] = longint'(ln.dir_z);
    for (int k = 0; k < 3; k++) begin
      diff[k] = org[k] - longint'($signed(box_regs[REG_BOX_CENTER][k*COORD_WIDTH +: COORD_WIDTH]));
    end
    for (int i = 0; i < 3; i++) begin
      so = 0;
      sd = 0;
      for (int k = 0; k < 3; k++) begin
        a = longint'($signed(box_regs[REG_BOX_AXIS0 + i][k*AXIS_WIDTH +: AXIS_WIDTH]));
        so += diff[k] * a;
        sd += dir[k] * a;
      end
      bo[i] = so;
      bd[i] = round_div_pow2(sd, AXIS_FRAC_BITS);
    end
    t0 = -(longint'(1) <<< 31);
    t1 = (longint'(1) <<< 31) - 1;
    alive = 1'b1;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (alive) begin
        ax = f / 2;
        ext = longint'(box_regs[REG_BOX_EXTENTS][ax*COORD_WIDTH +: COORD_WIDTH])
              <<< AXIS_FRAC_BITS;
        denom = (f % 2) ? -bd[ax] : bd[ax];
        numer = ((f % 2) ? bo[ax] : -bo[ax]) - ext;
        if (denom == 0) begin
          if (numer > 0) alive = 1'b0;
        end else begin
          // SystemVerilog division truncates toward zero
          q = clamp_signed((numer <<< T_SHIFT) / denom, T_WIDTH);
          if (denom > 0) begin
            if (q > t1) alive = 1'b0;
            else if (q > t0) t0 = q;
          end else begin
            if (q < t0) alive = 1'b0;
            else if (q < t1) t1 = q;
          end
        end
      end
    end
    r = '0;
    if (alive) begin
      if (t1 > t0) begin
        r.hit_count = HIT_CROSS;
      end else begin
        r.hit_count = HIT_TOUCH;
        t1 = t0;
      end
      r.t_enter = t0[T_WIDTH-1:0];
      r.t_exit = t1[T_WIDTH-1:0];
      for (int k = 0; k < 3; k++) begin
        pt[0][k] = COORD_WIDTH'(clamp_signed(org[k] + round_div_pow2(t0 * dir[k], P_SHIFT),
                                             COORD_WIDTH));
        pt[1][k] = COORD_WIDTH'(clamp_signed(org[k] + round_div_pow2(t1 * dir[k], P_SHIFT),
                                             COORD_WIDTH));
      end
      r.enter_x = pt[0][0]; r.enter_y = pt[0][1]; r.enter_z = pt[0][2];
      r.exit_x = pt[1][0]; r.exit_y = pt[1][1]; r.exit_z = pt[1][2];
    end
    return r;
  endfunction

  // Driver: hold start until the transaction is taken, idle at random
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_hits.push_back(clip_line(line));
        lines_sent <= lines_sent + 1;
      end
      if (!start || !busy) begin
        if (pending_lines.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          line <= pending_lines.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR: unexpected result %h", result);
      end else begin
        exp_r = expected_hits.pop_front();
        if (exp_r.hit_count <= HIT_CROSS) hits_by_count[exp_r.hit_count]++;
        if (result !== exp_r) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result mismatch");
            $display("  hit_count exp %0d got %0d", exp_r.hit_count, result.hit_count);
            $display("  t exp %0d %0d got %0d %0d", exp_r.t_enter, exp_r.t_exit,
                     result.t_enter, result.t_exit);
            $display("  enter exp %0d %0d %0d got %0d %0d %0d", exp_r.enter_x,
                     exp_r.enter_y, exp_r.enter_z, result.enter_x, result.enter_y,
                     result.enter_z);
            $display("  exit exp %0d %0d %0d got %0d %0d %0d", exp_r.exit_x,
                     exp_r.exit_y, exp_r.exit_z, result.exit_x, result.exit_y,
                     result.exit_z);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    box_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pack_axis(int x, int y, int z);
    logic [CFG_W-1:0] v;
    v = '0;
    v[0 +: AXIS_WIDTH] = AXIS_WIDTH'(x);
    v[AXIS_WIDTH +: AXIS_WIDTH] = AXIS_WIDTH'(y);
    v[2*AXIS_WIDTH +: AXIS_WIDTH] = AXIS_WIDTH'(z);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pack_coord(int x, int y, int z);
    return {z[COORD_WIDTH-1:0], y[COORD_WIDTH-1:0], x[COORD_WIDTH-1:0]};
  endfunction

  function automatic line_in_t make_line(int ox, int oy, int oz, int dx, int dy, int dz);
    line_in_t l;
    l.origin_x = COORD_WIDTH'(ox); l.origin_y = COORD_WIDTH'(oy);
    l.origin_z = COORD_WIDTH'(oz);
    l.dir_x = AXIS_WIDTH'(dx); l.dir_y = AXIS_WIDTH'(dy); l.dir_z = AXIS_WIDTH'(dz);
    return l;
  endfunction

  // A line aimed near the box, or pure noise now and then
  function automatic line_in_t random_line();
    line_in_t l;
    int one;
    one = 1 << AXIS_FRAC_BITS;
    l = line_in_t'(LINE_BITS'({$urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(9) < 7) begin
      l.origin_x = $signed(box_regs[REG_BOX_CENTER][0 +: COORD_WIDTH])
                   + $signed(20'($urandom_range(8191) - 4096));
      l.origin_y = $signed(box_regs[REG_BOX_CENTER][COORD_WIDTH +: COORD_WIDTH])
                   + $signed(20'($urandom_range(8191) - 4096));
      l.origin_z = $signed(box_regs[REG_BOX_CENTER][2*COORD_WIDTH +: COORD_WIDTH])
                   + $signed(20'($urandom_range(8191) - 4096));
      l.dir_x = AXIS_WIDTH'($urandom_range(2*one) - one);
      l.dir_y = AXIS_WIDTH'($urandom_range(2*one) - one);
      l.dir_z = AXIS_WIDTH'($urandom_range(2*one) - one);
      if ($urandom_range(3) == 0) l.dir_y = '0;
    end
    return l;
  endfunction

  task automatic wait_drain();
    while (pending_lines.size() > 0 || start || expected_hits.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_box();
    write_reg(REG_BOX_CENTER, pack_coord($urandom_range(8191) - 4096,
              $urandom_range(8191) - 4096, $urandom_range(8191) - 4096));
    write_reg(REG_BOX_EXTENTS, pack_coord($urandom_range(4096), $urandom_range(4096),
              $urandom_range(4096)));
    write_reg(REG_BOX_AXIS0, CFG_W'({16'($urandom), $urandom}));
    write_reg(REG_BOX_AXIS1, CFG_W'({16'($urandom), $urandom}));
    write_reg(REG_BOX_AXIS2, CFG_W'({16'($urandom), $urandom}));
  endtask

  initial begin
    int one;
    int pct [4];
    one = 1 << AXIS_FRAC_BITS;
    pct = '{0, 60, 0, 29};
    for (int i = 0; i < 5; i++) box_regs[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero box: every line runs into parallel faces
    pending_lines.push_back(make_line(0, 0, 0, 0, 0, 0));
    pending_lines.push_back(make_line(5, 0, 0, one, 0, 0));
    wait_drain();

    // Axis-aligned unit box
    write_reg(REG_BOX_CENTER, pack_coord(0, 0, 0));
    write_reg(REG_BOX_EXTENTS, pack_coord(1024, 1024, 1024));
    write_reg(REG_BOX_AXIS0, pack_axis(one, 0, 0));
    write_reg(REG_BOX_AXIS1, pack_axis(0, one, 0));
    write_reg(REG_BOX_AXIS2, pack_axis(0, 0, one));
    pending_lines.push_back(make_line(-4096, 0, 0, one, 0, 0));
    pending_lines.push_back(make_line(0, 0, 0, -one, 0, 0));
    pending_lines.push_back(make_line(0, 5000, 0, one, 0, 0));
    pending_lines.push_back(make_line(0, 1024, 0, one, 0, 0));
    pending_lines.push_back(make_line(0, 0, 0, 0, 0, 0));
    pending_lines.push_back(make_line(1024, 1024, 1024, one, -one, 0));
    pending_lines.push_back(make_line(-524288, -524288, -524288, -32768, -32768, -32768));
    pending_lines.push_back(make_line(524287, 524287, 524287, 32767, 32767, 32767));
    pending_lines.push_back(make_line(0, 0, 0, 1, 0, 0));
    pending_lines.push_back(make_line(-2048, -2048, -2048, one, one, one));
    pending_lines.push_back(make_line(0, 0, 0, 32767, -32768, 1));
    wait_drain();

    // Extreme box settings
    write_reg(REG_BOX_CENTER, {CFG_W{1'b1}});
    write_reg(REG_BOX_EXTENTS, {CFG_W{1'b1}});
    write_reg(REG_BOX_AXIS0, pack_axis(-32768, 32767, 0));
    write_reg(REG_BOX_AXIS1, pack_axis(32767, 32767, 32767));
    write_reg(REG_BOX_AXIS2, pack_axis(-32768, -32768, -32768));
    pending_lines.push_back(make_line(0, 0, 0, one, 0, 0));
    pending_lines.push_back(make_line(-524288, 524287, 0, 32767, -32768, 0));
    pending_lines.push_back(make_line(100, -100, 7, 0, 0, one));
    wait_drain();

    // Random phases with a fresh box each time
    for (int ph = 0; ph < 16; ph++) begin
      random_box();
      send_idle_pct = pct[ph % 4];
      for (int n = 0; n < 110; n++) pending_lines.push_back(random_line());
      wait_drain();
    end
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
      if (stim_done && expected_hits.size() == 0 && pending_lines.size() == 0
          && !start) begin
        repeat (LATENCY + 5) @(posedge clk);
        break;
      end
    end
    $display("Ran %0d lines over 19 box settings; %0d results checked", lines_sent,
             results_seen);
    $display("Misses %0d, touches %0d, crossings %0d, mismatches %0d", hits_by_count[0],
             hits_by_count[1], hits_by_count[2], mismatches);
    if (timed_out) begin
      $display("Test completed with failures");
    end else if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
